@@ rtl/aga_pkg.sv @@
// shared types and constants for the adjacent resource grant arbiter
package aga_pkg;

  localparam int NUM_REQUESTERS_DEF = 5;

  localparam int REQ_TYPE_W  = 2;
  localparam int REQUESTER_W = 3;
  localparam int GRANT_W     = 3;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [REQ_TYPE_W-1:0] {
    KIND_REQUEST = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TOGGLE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_REQ,
    OP_REL,
    OP_CHK
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
    logic paused;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    SEQ_REQ,
    SEQ_REL,
    SEQ_SCAN
  } seq_t;

endpackage

@@ rtl/aga_cell.sv @@
// one ring position: its resource flag and its waiting flag
module aga_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  aga_pkg::cell_cmd_t  cmd_i,
  input  logic                sel_i,
  input  logic                left_used_i,
  input  logic                take_right_i,
  input  logic                free_right_i,
  output logic                used_o,
  output logic                take_o,
  output logic                free_o,
  output logic                grant_o
);

  logic used_r, used_nxt;
  logic waiting_r, waiting_nxt;
  logic fit;
  logic act;
  logic grant;

  always_comb begin
    used_nxt    = used_r;
    waiting_nxt = waiting_r;
    grant       = 1'b0;
    free_o      = 1'b0;
    fit         = !used_r && !left_used_i;
    act         = cmd_i.valid && sel_i;
    // right neighbor grabbing or dropping the resource it shares with us
    if (take_right_i) begin
      used_nxt = 1'b1;
    end
    if (free_right_i) begin
      used_nxt = 1'b0;
    end
    if (act) begin
      case (cmd_i.op)
        aga_pkg::OP_REQ: begin
          if (!waiting_r) begin
            if (!cmd_i.paused && fit) begin
              grant = 1'b1;
            end else begin
              waiting_nxt = 1'b1;
            end
          end
        end
        aga_pkg::OP_REL: begin
          used_nxt = 1'b0;
          free_o   = 1'b1;
        end
        aga_pkg::OP_CHK: begin
          if (waiting_r && fit) begin
            grant       = 1'b1;
            waiting_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (grant) begin
      used_nxt = 1'b1;
    end
    take_o  = grant;
    grant_o = grant;
    used_o  = used_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= 1'b0;
      waiting_r <= 1'b0;
    end else begin
      used_r    <= used_nxt;
      waiting_r <= waiting_nxt;
    end
  end

endmodule

@@ rtl/aga_ctrl.sv @@
// sequencer: walks the ring positions an item touches and collects grants
module aga_ctrl #(
  parameter int NUM_REQUESTERS = aga_pkg::NUM_REQUESTERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [aga_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [aga_pkg::GRANT_W-1:0]     out_grant_index,
  output logic                            out_last,
  input  logic [NUM_REQUESTERS-1:0]       grant_vec_i,
  output aga_pkg::cell_cmd_t              cmd_o,
  output logic [NUM_REQUESTERS-1:0]       sel_o
);

  localparam int IW = $clog2(NUM_REQUESTERS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_REQUESTERS - 1);

  aga_pkg::state_t state_r, state_nxt;
  aga_pkg::seq_t   seq_r, seq_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [IW-1:0]   base_r, base_nxt;
  logic            paused_r, paused_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  logic [aga_pkg::GRANT_W-1:0] pend_idx_r, pend_idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [aga_pkg::GRANT_W-1:0] out_idx_r, out_idx_nxt;
  logic            out_last_r, out_last_nxt;

  aga_pkg::kind_t                 in_kind;
  logic [aga_pkg::REQUESTER_W-1:0] in_who;
  logic                           in_range;
  logic                           grant_any;
  logic                           out_free;
  logic                           can_go;
  logic                           final_step;
  logic [IW-1:0]                  base_right;
  logic [IW-1:0]                  base_left;

  assign in_kind  = aga_pkg::kind_t'(in_tdata[aga_pkg::REQ_TYPE_W-1:0]);
  assign in_who   = in_tdata[aga_pkg::REQ_TYPE_W +: aga_pkg::REQUESTER_W];
  assign in_range = 32'(in_who) < NUM_REQUESTERS;
  assign grant_any = |grant_vec_i;
  assign out_free  = !out_valid_r || out_tready;
  assign can_go    = !pend_valid_r || out_free;
  assign base_right = (base_r == '0) ? LAST_IDX : base_r - 1'b1;
  assign base_left  = (base_r == LAST_IDX) ? '0 : base_r + 1'b1;

  assign in_tready       = (state_r == aga_pkg::ST_IDLE);
  assign out_tvalid      = out_valid_r;
  assign out_grant_index = out_idx_r;
  assign out_last        = out_last_r;

  always_comb begin
    for (int i = 0; i < NUM_REQUESTERS; i++) begin
      sel_o[i] = (idx_r == IW'(i));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    seq_nxt        = seq_r;
    phase_nxt      = phase_r;
    idx_nxt        = idx_r;
    base_nxt       = base_r;
    paused_nxt     = paused_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    cmd_o.valid    = 1'b0;
    cmd_o.op       = aga_pkg::OP_CHK;
    cmd_o.paused   = paused_r;
    final_step     = 1'b0;

    case (seq_r)
      aga_pkg::SEQ_REQ: begin
        cmd_o.op   = aga_pkg::OP_REQ;
        final_step = 1'b1;
      end
      aga_pkg::SEQ_REL: begin
        if (phase_r == 2'd0) begin
          cmd_o.op   = aga_pkg::OP_REL;
          final_step = paused_r;
        end else begin
          cmd_o.op   = aga_pkg::OP_CHK;
          final_step = (phase_r == 2'd2);
        end
      end
      aga_pkg::SEQ_SCAN: begin
        cmd_o.op   = aga_pkg::OP_CHK;
        final_step = (idx_r == LAST_IDX);
      end
      default: begin
        final_step = 1'b1;
      end
    endcase

    case (state_r)
      aga_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_kind)
            aga_pkg::KIND_TOGGLE: begin
              paused_nxt = !paused_r;
              if (paused_r) begin
                seq_nxt   = aga_pkg::SEQ_SCAN;
                idx_nxt   = '0;
                state_nxt = aga_pkg::ST_STEP;
              end
            end
            aga_pkg::KIND_REQUEST: begin
              if (in_range) begin
                seq_nxt   = aga_pkg::SEQ_REQ;
                idx_nxt   = IW'(in_who);
                state_nxt = aga_pkg::ST_STEP;
              end
            end
            aga_pkg::KIND_RELEASE: begin
              if (in_range) begin
                seq_nxt   = aga_pkg::SEQ_REL;
                idx_nxt   = IW'(in_who);
                base_nxt  = IW'(in_who);
                phase_nxt = 2'd0;
                state_nxt = aga_pkg::ST_STEP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      aga_pkg::ST_STEP: begin
        if (can_go) begin
          cmd_o.valid = 1'b1;
          if (grant_any) begin
            // an earlier grant is known not to be the final one now
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = pend_idx_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = aga_pkg::GRANT_W'(idx_r);
          end
          if (final_step) begin
            state_nxt = (pend_valid_r || grant_any) ? aga_pkg::ST_FLUSH : aga_pkg::ST_IDLE;
          end else if (seq_r == aga_pkg::SEQ_REL) begin
            phase_nxt = phase_r + 2'd1;
            idx_nxt   = (phase_r == 2'd0) ? base_right : base_left;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      aga_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = pend_idx_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = aga_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = aga_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aga_pkg::ST_IDLE;
      seq_r        <= aga_pkg::SEQ_REQ;
      phase_r      <= 2'd0;
      idx_r        <= '0;
      paused_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seq_r        <= seq_nxt;
      phase_r      <= phase_nxt;
      idx_r        <= idx_nxt;
      paused_r     <= paused_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  // no grant is left over once the block takes a new item
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_valid_r)
    else $error("pending grant while idle");

  // grants come only from a cell that was commanded this cycle
  a_grant_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    grant_any |-> cmd_o.valid && (state_r == aga_pkg::ST_STEP))
    else $error("grant without command");

  a_grant_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(grant_vec_i))
    else $error("more than one cell granted");

  // a grant is never lost: a pending one moves to a free output slot
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    grant_any && pend_valid_r |-> out_free)
    else $error("pending grant overwritten");

  a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aga_pkg::ST_FLUSH) |-> pend_valid_r)
    else $error("flush with nothing pending");

endmodule

@@ rtl/adjacent_resource_grant_arbiter.sv @@
// top level: sequencer and a ring of arbiter cells
// an item is taken while the sequencer is idle, then runs one step per cycle across the ring unless stalled
// request: 1 step, release: 1 step paused or 3 serving, resume: NUM_REQUESTERS steps
// the flush state then hands over the final grant of an item that made one
// one sequencer step a cycle sets the rate; a full output register stalls the steps
// rst_n (synchronous, active low) frees all resources, clears waiting and paused mode
module adjacent_resource_grant_arbiter #(
  parameter int NUM_REQUESTERS = aga_pkg::NUM_REQUESTERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [1:0] req_type, [4:2] requester, [7:5] zero
  input  logic [aga_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [2:0] grant_index, [7:3] zero
  output logic [aga_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);

  aga_pkg::cell_cmd_t                 cmd;
  logic [NUM_REQUESTERS-1:0]          sel;
  logic [NUM_REQUESTERS-1:0]          used;
  logic [NUM_REQUESTERS-1:0]          take;
  logic [NUM_REQUESTERS-1:0]          free;
  logic [NUM_REQUESTERS-1:0]          grant_vec;
  logic [aga_pkg::GRANT_W-1:0]        grant_index;

  aga_ctrl #(
    .NUM_REQUESTERS(NUM_REQUESTERS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_grant_index (grant_index),
    .out_last        (out_tlast),
    .grant_vec_i     (grant_vec),
    .cmd_o           (cmd),
    .sel_o           (sel)
  );

  // cell i shares its left resource with cell i+1 around the ring
  for (genvar i = 0; i < NUM_REQUESTERS; i++) begin : g_cell
    aga_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd_i        (cmd),
      .sel_i        (sel[i]),
      .left_used_i  (used[(i + 1) % NUM_REQUESTERS]),
      .take_right_i (take[(i + NUM_REQUESTERS - 1) % NUM_REQUESTERS]),
      .free_right_i (free[(i + NUM_REQUESTERS - 1) % NUM_REQUESTERS]),
      .used_o       (used[i]),
      .take_o       (take[i]),
      .free_o       (free[i]),
      .grant_o      (grant_vec[i])
    );
  end

  assign out_tdata = {{(aga_pkg::OUT_DATA_W - aga_pkg::GRANT_W){1'b0}}, grant_index};

endmodule

@@ tb/testbench.sv @@
// testbench for the adjacent resource grant arbiter: directed table, then random traffic
`timescale 1ns / 100ps

module testbench;

  localparam int NREQ = aga_pkg::NUM_REQUESTERS_DEF;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 196;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NO_TYPED = -1;

  typedef struct packed {
    logic [aga_pkg::GRANT_W-1:0] grant_index;
    logic                        last;
  } grant_t;

  typedef struct {
    logic [aga_pkg::REQ_TYPE_W-1:0]  kind;
    logic [aga_pkg::REQUESTER_W-1:0] who;
    int                              typed_cnt;
    logic [aga_pkg::GRANT_W-1:0]     typed_first;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [aga_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [aga_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;

  // predictor state
  logic fork_busy [NREQ];
  logic hungry [NREQ];
  logic paused;

  grant_t grant_q[$];
  step_row_t sent_q[$];
  step_row_t table_q[$];
  int fail_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;

  adjacent_resource_grant_arbiter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[adjacent_resource_grant_arbiter] ERROR");
      $finish;
    end
  end

  // works out the grants one accepted item makes, in grant order
  function automatic int predict_grants(input logic [1:0] kind, input logic [2:0] who);
    grant_t fresh[$];
    grant_t g;
    int n, m, k;
    fresh = {};
    if (kind == aga_pkg::KIND_TOGGLE) begin
      if (!paused) begin
        paused = 1'b1;
      end else begin
        paused = 1'b0;
        for (k = 0; k < NREQ; k++) begin
          m = (k + 1) % NREQ;
          if (hungry[k] && !fork_busy[m] && !fork_busy[k]) begin
            fork_busy[m] = 1'b1;
            fork_busy[k] = 1'b1;
            hungry[k] = 1'b0;
            g.grant_index = aga_pkg::GRANT_W'(k);
            g.last = 1'b0;
            fresh.push_back(g);
          end
        end
      end
    end else if (kind == aga_pkg::KIND_REQUEST && who < NREQ) begin
      n = int'(who);
      if (!hungry[n]) begin
        m = (n + 1) % NREQ;
        if (!paused && !fork_busy[m] && !fork_busy[n]) begin
          fork_busy[m] = 1'b1;
          fork_busy[n] = 1'b1;
          g.grant_index = aga_pkg::GRANT_W'(n);
          g.last = 1'b0;
          fresh.push_back(g);
        end else begin
          hungry[n] = 1'b1;
        end
      end
    end else if (kind == aga_pkg::KIND_RELEASE && who < NREQ) begin
      n = int'(who);
      fork_busy[(n + 1) % NREQ] = 1'b0;
      fork_busy[n] = 1'b0;
      if (!paused) begin
        // right neighbor first, then left neighbor
        m = (n + NREQ - 1) % NREQ;
        if (hungry[m] && !fork_busy[m]) begin
          fork_busy[n] = 1'b1;
          fork_busy[m] = 1'b1;
          hungry[m] = 1'b0;
          g.grant_index = aga_pkg::GRANT_W'(m);
          g.last = 1'b0;
          fresh.push_back(g);
        end
        m = (n + 1) % NREQ;
        k = (m + 1) % NREQ;
        if (hungry[m] && !fork_busy[k]) begin
          fork_busy[m] = 1'b1;
          fork_busy[k] = 1'b1;
          hungry[m] = 1'b0;
          g.grant_index = aga_pkg::GRANT_W'(m);
          g.last = 1'b0;
          fresh.push_back(g);
        end
      end
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[i]) grant_q.push_back(fresh[i]);
    return fresh.size();
  endfunction

  // result check first, then prediction for the item taken at this edge
  always @(posedge clk) begin
    grant_t want;
    step_row_t row;
    int cnt;
    if (!rst_n) begin
      foreach (fork_busy[i]) begin
        fork_busy[i] = 1'b0;
        hungry[i] = 1'b0;
      end
      paused = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (grant_q.size() == 0) begin
          $error("grant transfer with nothing expected: grant_index %0d last %0d",
                 out_tdata[aga_pkg::GRANT_W-1:0], out_tlast);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (out_tdata[aga_pkg::GRANT_W-1:0] !== want.grant_index) begin
            $error("grant_index expected %0d actual %0d",
                   want.grant_index, out_tdata[aga_pkg::GRANT_W-1:0]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last expected %0d actual %0d", want.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        row = sent_q.pop_front();
        cnt = predict_grants(in_tdata[1:0], in_tdata[4:2]);
        if (row.typed_cnt != NO_TYPED) begin
          if (cnt != row.typed_cnt) begin
            $error("grant count expected %0d actual %0d", row.typed_cnt, cnt);
            fail_count++;
          end else if (cnt > 0 && grant_q[grant_q.size()-cnt].grant_index != row.typed_first) begin
            $error("first grant_index expected %0d actual %0d", row.typed_first,
                   grant_q[grant_q.size()-cnt].grant_index);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver stall pattern, switching style now and then
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 99) < 60);
      default: out_tready <= ((rx_cycle % 9) < 2);
    endcase
  end

  task automatic send_item(input logic [1:0] kind, input logic [2:0] who,
                           input int typed_cnt, input logic [2:0] typed_first);
    step_row_t row;
    int gap;
    row.kind = kind;
    row.who = who;
    row.typed_cnt = typed_cnt;
    row.typed_first = typed_first;
    sent_q.push_back(row);
    @(negedge clk);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      // long bursts give stretches with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {{(aga_pkg::IN_DATA_W-aga_pkg::REQ_TYPE_W-aga_pkg::REQUESTER_W){1'b0}},
                 who, kind};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic add_row(input logic [1:0] kind, input logic [2:0] who,
                         input int typed_cnt, input logic [2:0] typed_first);
    step_row_t row;
    row.kind = kind;
    row.who = who;
    row.typed_cnt = typed_cnt;
    row.typed_first = typed_first;
    table_q.push_back(row);
  endtask

  initial begin
    int counted;
    int pick;
    logic [1:0] kind;
    logic [2:0] who;

    add_row(aga_pkg::KIND_REQUEST, 3'd0, 1, 3'd0);
    add_row(aga_pkg::KIND_REQUEST, 3'd1, 0, 3'd0);        // neighbor busy, waits
    add_row(aga_pkg::KIND_REQUEST, 3'd1, 0, 3'd0);        // repeated request
    add_row(aga_pkg::KIND_RELEASE, 3'd0, 1, 3'd1);        // left neighbor now fits
    add_row(aga_pkg::KIND_REQUEST, 3'd7, 0, 3'd0);        // out of range
    add_row(aga_pkg::KIND_RELEASE, 3'd5, 0, 3'd0);        // out of range
    add_row(KIND_UNKNOWN, 3'd7, 0, 3'd0);
    add_row(KIND_UNKNOWN, 3'd0, 0, 3'd0);
    add_row(aga_pkg::KIND_REQUEST, 3'd3, 1, 3'd3);
    add_row(aga_pkg::KIND_REQUEST, 3'd4, 0, 3'd0);
    add_row(aga_pkg::KIND_REQUEST, 3'd3, 0, 3'd0);        // holder asks again and waits
    add_row(aga_pkg::KIND_TOGGLE, 3'd0, 0, 3'd0);         // pause
    add_row(aga_pkg::KIND_RELEASE, 3'd1, 0, 3'd0);
    add_row(aga_pkg::KIND_REQUEST, 3'd0, 0, 3'd0);
    add_row(aga_pkg::KIND_RELEASE, 3'd3, 0, 3'd0);
    add_row(aga_pkg::KIND_REQUEST, 3'd2, NO_TYPED, 3'd0);
    add_row(aga_pkg::KIND_TOGGLE, 3'd0, NO_TYPED, 3'd0);  // resume scan
    add_row(aga_pkg::KIND_RELEASE, 3'd4, NO_TYPED, 3'd0); // release by non-holder
    add_row(aga_pkg::KIND_RELEASE, 3'd3, NO_TYPED, 3'd0);
    add_row(aga_pkg::KIND_RELEASE, 3'd0, NO_TYPED, 3'd0);
    add_row(aga_pkg::KIND_RELEASE, 3'd2, NO_TYPED, 3'd0);
    add_row(aga_pkg::KIND_TOGGLE, 3'd7, NO_TYPED, 3'd0);
    add_row(aga_pkg::KIND_TOGGLE, 3'd0, NO_TYPED, 3'd0);  // resume while requester 3 still waits
    add_row(aga_pkg::KIND_RELEASE, 3'd4, NO_TYPED, 3'd0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (table_q[i])
      send_item(table_q[i].kind, table_q[i].who, table_q[i].typed_cnt, table_q[i].typed_first);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 46) begin
        kind = aga_pkg::KIND_REQUEST;
        who = 3'($urandom_range(0, NREQ - 1));
      end else if (pick < 86) begin
        kind = aga_pkg::KIND_RELEASE;
        who = 3'($urandom_range(0, NREQ - 1));
      end else if (pick < 93) begin
        kind = aga_pkg::KIND_TOGGLE;
        who = 3'($urandom_range(0, 7));
      end else begin
        // noise: unknown kind, requester out of range, or a toggle with an unused requester field
        kind = 2'($urandom_range(0, 3));
        who = (kind == KIND_UNKNOWN) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(NREQ, 7));
      end
      counted++;
      send_item(kind, who, NO_TYPED, 3'd0);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (fail_count == 0) begin
      $display("[adjacent_resource_grant_arbiter] OK");
    end else begin
      $display("[adjacent_resource_grant_arbiter] ERROR");
    end
    $finish;
  end

endmodule
